// ===== rtl/dmx_channel_capture_core_macros.svh =====
// Assertion macros for the DMX channel capture block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef DMX_CHANNEL_CAPTURE_CORE_MACROS_SVH
`define DMX_CHANNEL_CAPTURE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DMXCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DMXCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dmxcc_pkg.sv =====
`default_nettype none

package dmxcc_pkg;

  // Number of captured slots per frame
  localparam int unsigned NumChannels = 8;
  // Number of channel fields on the result transaction
  localparam int unsigned OutFields   = 8;
  // Index width into the capture store
  localparam int unsigned IdxW        = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 10;

  localparam logic [CntW-1:0] StartAddrReset = CntW'(1);
  localparam logic [ByteW-1:0] StartCodeDmx  = '0;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CntW-1:0]  cnt_t;

  // Input transaction payload
  typedef struct packed {
    byte_t rx_byte;
    logic  framing_error;
  } rx_item_t;

endpackage

`default_nettype wire

// ===== rtl/dmxcc_ifs.sv =====
`default_nettype none

// Received byte channel
interface dmxcc_rx_if;
  logic                valid;
  logic                ready;
  dmxcc_pkg::byte_t    rx_byte;
  logic                framing_error;

  modport source (output valid, output rx_byte, output framing_error, input ready);
  modport sink   (input valid, input rx_byte, input framing_error, output ready);
endinterface

// Captured channel result channel
interface dmxcc_chan_if;
  logic             valid;
  logic             ready;
  dmxcc_pkg::byte_t chan0;
  dmxcc_pkg::byte_t chan1;
  dmxcc_pkg::byte_t chan2;
  dmxcc_pkg::byte_t chan3;
  dmxcc_pkg::byte_t chan4;
  dmxcc_pkg::byte_t chan5;
  dmxcc_pkg::byte_t chan6;
  dmxcc_pkg::byte_t chan7;

  modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                  output chan4, output chan5, output chan6, output chan7, input ready);
  modport sink   (input valid, input chan0, input chan1, input chan2, input chan3,
                  input chan4, input chan5, input chan6, input chan7, output ready);
endinterface

`default_nettype wire

// ===== rtl/dmx_channel_capture_core.sv =====
`default_nettype none

// Channel  | Direction | Contents
// rx_i     | in        | rx_byte[7:0], framing_error
// chan_o   | out       | chan0..chan7[7:0], reported channel set
// cfg      | in        | start_address_we_i, start_address_i[9:0]
//
// One byte transaction per cycle unless the pipe is stalled; the last byte of a
// changed frame passes the input register, then the result register holds its set.
// The phase/slot update and the eight-byte compare sit between those registers.
// Reset clears phase, slot counter and both channel stores; start address is 1.
// A stalled result holds the pipe only once the input register is also full.

module dmx_channel_capture_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_address_we_i,
  input  wire dmxcc_pkg::cnt_t  start_address_i,
  dmxcc_rx_if.sink              rx_i,
  dmxcc_chan_if.source          chan_o
);

  typedef enum logic [1:0] {
    PhIdle,
    PhBreak,
    PhSeek,
    PhCapture
  } phase_e;

  localparam int unsigned N = dmxcc_pkg::NumChannels;

  phase_e              phase_q, phase_d;
  dmxcc_pkg::cnt_t     slot_q, slot_d;
  dmxcc_pkg::cnt_t     start_addr_q;
  dmxcc_pkg::byte_t    capt_q [N];
  dmxcc_pkg::byte_t    capt_d [N];
  dmxcc_pkg::byte_t    rep_q  [N];
  dmxcc_pkg::byte_t    rep_d  [N];
  dmxcc_pkg::rx_item_t in_q;
  logic                in_valid_q;
  logic                out_valid_q;
  dmxcc_pkg::byte_t    chan_q [dmxcc_pkg::OutFields];
  dmxcc_pkg::byte_t    chan_d [dmxcc_pkg::OutFields];

  logic            advance;
  logic            work;
  logic            done;
  logic            changed;
  logic            emit;
  dmxcc_pkg::cnt_t cnt_dec;
  dmxcc_pkg::cnt_t cnt_inc;

  // Advance the pipe when the result register is free or being drained
  assign advance  = !out_valid_q || chan_o.ready;
  assign work     = advance && in_valid_q;
  assign rx_i.ready = !in_valid_q || advance;

  assign cnt_dec = slot_q - dmxcc_pkg::CntW'(1);
  assign cnt_inc = slot_q + dmxcc_pkg::CntW'(1);

  // Phase and slot update, capture write, frame compare
  always_comb begin
    phase_d = phase_q;
    slot_d  = slot_q;
    done    = 1'b0;
    for (int i = 0; i < N; i++) begin
      capt_d[i] = capt_q[i];
    end
    if (in_q.framing_error) begin
      slot_d  = start_addr_q;
      phase_d = PhBreak;
    end else begin
      case (phase_q)
        PhBreak: begin
          phase_d = (in_q.rx_byte == dmxcc_pkg::StartCodeDmx) ? PhSeek : PhIdle;
        end
        PhSeek: begin
          slot_d = cnt_dec;
          if (cnt_dec == '0) begin
            capt_d[0] = in_q.rx_byte;
            slot_d    = dmxcc_pkg::CntW'(1);
            if (N <= 1) begin
              done    = 1'b1;
              phase_d = PhIdle;
            end else begin
              phase_d = PhCapture;
            end
          end
        end
        PhCapture: begin
          if (slot_q < dmxcc_pkg::CntW'(N)) begin
            capt_d[slot_q[dmxcc_pkg::IdxW-1:0]] = in_q.rx_byte;
          end
          slot_d = cnt_inc;
          if (cnt_inc >= dmxcc_pkg::CntW'(N)) begin
            done    = 1'b1;
            phase_d = PhIdle;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    changed = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (capt_d[i] != rep_q[i]) begin
        changed = 1'b1;
      end
    end
    emit = done && changed;

    for (int i = 0; i < N; i++) begin
      rep_d[i] = emit ? capt_d[i] : rep_q[i];
    end
    for (int i = 0; i < dmxcc_pkg::OutFields; i++) begin
      chan_d[i] = (i < N) ? capt_d[(i < N) ? i : 0] : '0;
    end
  end

  // Hold state, input register and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      slot_q       <= '0;
      start_addr_q <= dmxcc_pkg::StartAddrReset;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < N; i++) begin
        capt_q[i] <= '0;
        rep_q[i]  <= '0;
      end
    end else begin
      if (start_address_we_i) begin
        start_addr_q <= start_address_i;
      end
      if (rx_i.ready) begin
        in_valid_q <= rx_i.valid;
      end
      if (work) begin
        phase_q <= phase_d;
        slot_q  <= slot_d;
        for (int i = 0; i < N; i++) begin
          capt_q[i] <= capt_d[i];
          rep_q[i]  <= rep_d[i];
        end
      end
      if (advance) begin
        out_valid_q <= work && emit;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_q.rx_byte       <= rx_i.rx_byte;
      in_q.framing_error <= rx_i.framing_error;
    end
    if (work && emit) begin
      for (int i = 0; i < dmxcc_pkg::OutFields; i++) begin
        chan_q[i] <= chan_d[i];
      end
    end
  end

  assign chan_o.valid = out_valid_q;
  assign chan_o.chan0 = chan_q[0];
  assign chan_o.chan1 = chan_q[1];
  assign chan_o.chan2 = chan_q[2];
  assign chan_o.chan3 = chan_q[3];
  assign chan_o.chan4 = chan_q[4];
  assign chan_o.chan5 = chan_q[5];
  assign chan_o.chan6 = chan_q[6];
  assign chan_o.chan7 = chan_q[7];

`include "dmx_channel_capture_core_macros.svh"

  // A processed break always lands in the break phase
  `DMXCC_ASSERT_NEXT(a_break_restarts, work && in_q.framing_error, phase_q == PhBreak, "break did not restart")

  // An emitted set's first channel matches the reported store
  `DMXCC_ASSERT_NEXT(a_emit_matches_store, work && emit, out_valid_q && (chan_q[0] == rep_q[0]), "result differs from reported store")

  // Capture index stays inside the store
  `DMXCC_ASSERT_NOW(a_capture_index, phase_q == PhCapture, (slot_q != '0) && (slot_q < dmxcc_pkg::CntW'(N)), "capture index out of range")

  // An empty input register always takes a transaction
  `DMXCC_ASSERT_NOW(a_empty_ready, !in_valid_q, rx_i.ready, "input register empty but not ready")

endmodule

`default_nettype wire
